// ----- hw/rtl/frustum_cull_test_defines.svh -----
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum cull check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum cull check failed");

`endif

// ----- hw/rtl/fct_pkg.sv -----
package fct_pkg;

    localparam int NUM_REGS   = 6;
    localparam int PLANES_DEF = 6;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int ADDR_W     = IDX_W + 3;
    localparam int DATA_W     = 64;

    localparam int COORD_W    = 20;
    localparam int NORM_W     = 14;
    localparam int OFF_W      = 22;
    localparam int RAD_W      = 19;
    localparam int FRAC_SHIFT = 12;
    localparam int PROD_W     = NORM_W + COORD_W;
    localparam int THR_W      = RAD_W + FRAC_SHIFT + 1;
    localparam int ACC_W      = PROD_W + 3;

    localparam logic CMD_SPHERE = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [OFF_W-1:0]   off_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [THR_W-1:0]   thr_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Register layout: d in 63:42, nz in 41:28, ny in 27:14, nx in 13:0
    typedef struct packed {
        off_t  d;
        norm_t nz;
        norm_t ny;
        norm_t nx;
    } plane_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        prod_t x;
        prod_t y;
        prod_t z;
    } prod3_t;

endpackage

// ----- hw/rtl/fct_cfg.sv -----
module fct_cfg (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [fct_pkg::ADDR_W-1:0]                   paddr,
    input  logic [fct_pkg::DATA_W-1:0]                   pwdata,
    output logic [fct_pkg::DATA_W-1:0]                   prdata,
    output logic                                         pready,
    output fct_pkg::plane_t [fct_pkg::NUM_REGS-1:0]      planes
);
    import fct_pkg::*;

    plane_t [NUM_REGS-1:0] plane_reg;
    plane_t [NUM_REGS-1:0] plane_next;
    logic   [IDX_W-1:0]    idx;
    logic                  wr;

    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign planes = plane_reg;

    // Writes beyond the last register fall through without effect
    always_comb
    begin
        plane_next = plane_reg;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (wr && (idx == IDX_W'(i)))
            begin
                plane_next[i] = plane_t'(pwdata);
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            if (idx == IDX_W'(i))
            begin
                prdata = DATA_W'(plane_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

endmodule

// ----- hw/rtl/fct_pipe.sv -----
module fct_pipe #(
    parameter int PLANES = fct_pkg::PLANES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fct_pkg::plane_t [fct_pkg::NUM_REGS-1:0] planes,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic                                    command,
    input  fct_pkg::coord_t                         lo_x,
    input  fct_pkg::coord_t                         lo_y,
    input  fct_pkg::coord_t                         lo_z,
    input  fct_pkg::coord_t                         hi_x,
    input  fct_pkg::coord_t                         hi_y,
    input  fct_pkg::coord_t                         hi_z,
    input  logic [fct_pkg::RAD_W-1:0]               radius,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic                                    visible
);
    import fct_pkg::*;

    plane_t lane_plane [PLANES];

    // Stage A: vertex select and threshold
    logic   a_valid_reg;
    vec_t   a_pt_reg   [PLANES];
    vec_t   a_pt_next  [PLANES];
    thr_t   a_thr_reg;
    thr_t   a_thr_next;
    // Stage B: products
    logic   b_valid_reg;
    prod3_t b_prod_reg  [PLANES];
    prod3_t b_prod_next [PLANES];
    thr_t   b_thr_reg;
    // Stage C: per-plane cull flags
    logic              c_valid_reg;
    logic [PLANES-1:0] c_cull_reg;
    logic [PLANES-1:0] c_cull_next;
    // Stage D: result register
    logic   visible_reg;
    logic   visible_next;
    logic   result_valid_reg;

    logic   a_en, b_en, c_en, d_en;
    logic   sphere;

    // Planes without a register stay zero and cull nothing
    for (genvar i = 0; i < PLANES; i++)
    begin : g_lane
        if (i < NUM_REGS)
        begin : g_reg
            assign lane_plane[i] = planes[i];
        end
        else
        begin : g_zero
            assign lane_plane[i] = '0;
        end
    end

    // Each stage moves when it is empty or the one after it moves
    assign d_en       = !result_valid_reg || !result_stall;
    assign c_en       = !c_valid_reg || d_en;
    assign b_en       = !b_valid_reg || c_en;
    assign a_en       = !a_valid_reg || b_en;
    assign item_stall = !a_en;

    assign sphere = (command == CMD_SPHERE);

    always_comb
    begin
        for (int i = 0; i < PLANES; i++)
        begin
            // Box: positive vertex, max where the normal is non-negative
            a_pt_next[i].x = (sphere || lane_plane[i].nx[NORM_W-1]) ? lo_x : hi_x;
            a_pt_next[i].y = (sphere || lane_plane[i].ny[NORM_W-1]) ? lo_y : hi_y;
            a_pt_next[i].z = (sphere || lane_plane[i].nz[NORM_W-1]) ? lo_z : hi_z;
        end
        a_thr_next = sphere ? (thr_t'(0) - thr_t'({1'b0, radius, {FRAC_SHIFT{1'b0}}}))
                            : thr_t'(0);
    end

    always_comb
    begin
        for (int i = 0; i < PLANES; i++)
        begin
            b_prod_next[i].x = prod_t'(lane_plane[i].nx) * prod_t'(a_pt_reg[i].x);
            b_prod_next[i].y = prod_t'(lane_plane[i].ny) * prod_t'(a_pt_reg[i].y);
            b_prod_next[i].z = prod_t'(lane_plane[i].nz) * prod_t'(a_pt_reg[i].z);
        end
    end

    always_comb
    begin
        for (int i = 0; i < PLANES; i++)
        begin
            c_cull_next[i] = (acc_t'(b_prod_reg[i].x) + acc_t'(b_prod_reg[i].y)
                              + acc_t'(b_prod_reg[i].z)
                              + (acc_t'(lane_plane[i].d) <<< FRAC_SHIFT))
                             < acc_t'(b_thr_reg);
        end
    end

    assign visible_next = ~|c_cull_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= item_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_en)
            begin
                result_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_pt_reg  <= a_pt_next;
            a_thr_reg <= a_thr_next;
        end
        if (b_en)
        begin
            b_prod_reg <= b_prod_next;
            b_thr_reg  <= a_thr_reg;
        end
        if (c_en)
        begin
            c_cull_reg <= c_cull_next;
        end
        if (d_en)
        begin
            visible_reg <= visible_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign visible      = visible_reg;

endmodule

// ----- hw/rtl/frustum_cull_test.sv -----
// Frustum culling test for axis-aligned boxes and spheres.
// Config: APB read/write port, 64-bit data, six plane registers at byte address 8*i
//   (left, right, bottom, top, near, far). Write planes only while no
//   transaction is in flight. pready is always high; reads return the register.
// Item channel: item_valid/item_stall with command (0 box, 1 sphere), lo_*,
//   hi_* and radius. Result channel: result_valid/result_stall with visible.
// Pipeline: an accepted transaction passes through four register stages
//   (vertex select, multiply, sum and compare, plane reduction) to the result.
// Throughput: one transaction per cycle while item_stall is low, all planes
//   evaluated in parallel lanes, one 14x20 multiplier per axis per lane.
// Stall: a stalled result holds; bubbles in the pipe are squeezed out, and
//   item_stall rises only when all four stages are full.
// Reset: planes clear to zero, so every shape is visible; the pipe empties.
module frustum_cull_test #(
    parameter int PLANES = fct_pkg::PLANES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fct_pkg::ADDR_W-1:0]    paddr,
    input  logic [fct_pkg::DATA_W-1:0]    pwdata,
    output logic [fct_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          command,
    input  fct_pkg::coord_t               lo_x,
    input  fct_pkg::coord_t               lo_y,
    input  fct_pkg::coord_t               lo_z,
    input  fct_pkg::coord_t               hi_x,
    input  fct_pkg::coord_t               hi_y,
    input  fct_pkg::coord_t               hi_z,
    input  logic [fct_pkg::RAD_W-1:0]     radius,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          visible
);
    import fct_pkg::*;

    plane_t [NUM_REGS-1:0] planes;

    fct_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    fct_pipe #(
        .PLANES (PLANES)
    ) u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .planes       (planes),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .lo_x         (lo_x),
        .lo_y         (lo_y),
        .lo_z         (lo_z),
        .hi_x         (hi_x),
        .hi_y         (hi_y),
        .hi_z         (hi_z),
        .radius       (radius),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .visible      (visible)
    );

endmodule

// ----- hw/rtl/fct_checker.sv -----
`include "frustum_cull_test_defines.svh"

module fct_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input logic visible
);

    // A stalled result stays and keeps its value
    `FCT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(visible))

    // Back-pressure on items only comes from a full, stalled output
    `FCT_ASSERT_NOW(a_stall_source, item_stall, result_valid && result_stall)

    // With the output flowing, an accepted transaction comes out as a valid result
    `FCT_ASSERT_NEXT(a_latency, (item_valid && !item_stall) ##1 !result_stall ##1 !result_stall ##1 !result_stall, result_valid)

endmodule

bind frustum_cull_test fct_checker u_fct_checker (.*);

// ----- bench/tb_frustum_cull_test.sv -----
module tb_frustum_cull_test;

    import fct_pkg::*;

    localparam int LANES = PLANES_DEF;
    localparam int SLOTS = 8;                 // address space holds eight plane slots
    localparam logic CMD_BOX = ~CMD_SPHERE;
    localparam int BY_MODEL = -1;
    localparam int CULLED = 0;
    localparam int SEEN = 1;
    localparam int C_TOP = 524287;
    localparam coord_t C_MIN = coord_t'(20'h80000);
    localparam coord_t C_MAX = coord_t'(20'h7FFFF);
    localparam logic [RAD_W-1:0] R_MAX = '1;
    localparam int EPOCHS = 5;
    localparam int PER_EPOCH = 130;
    localparam int HOLD_CYCLES = 80;
    localparam int PRINT_CAP = 40;

    typedef enum {PS_AFTER_RESET, PS_SLAB_X, PS_EXTREME} plane_set_e;

    typedef struct {
        plane_set_e       setup;
        logic             cmd;
        coord_t           lx, ly, lz;
        coord_t           hx, hy, hz;
        logic [RAD_W-1:0] rad;
        int               want;
    } probe_t;

    typedef struct {
        int   tag;
        logic vis;
    } due_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic              command = 1'b0;
    coord_t            lo_x = '0;
    coord_t            lo_y = '0;
    coord_t            lo_z = '0;
    coord_t            hi_x = '0;
    coord_t            hi_y = '0;
    coord_t            hi_z = '0;
    logic [RAD_W-1:0]  radius = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              visible;

    int                want_q = BY_MODEL;
    int                hold_asks = 0;
    logic              steady = 1'b0;

    logic [DATA_W-1:0] plane_shadow [NUM_REGS];
    due_t              visible_due [$];
    int                mismatch_count = 0;
    int                accepted_count = 0;

    // box rows: hi_x >= 0 passes the left plane, lo_x <= 1.0 passes the right one
    probe_t probes [22] = '{
        '{PS_AFTER_RESET, CMD_BOX, 0, 0, 0, 0, 0, 0, 0, SEEN},
        '{PS_AFTER_RESET, CMD_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, SEEN},
        '{PS_AFTER_RESET, CMD_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, R_MAX, SEEN},
        '{PS_AFTER_RESET, CMD_SPHERE, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0, SEEN},
        '{PS_AFTER_RESET, CMD_SPHERE, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, R_MAX, SEEN},
        '{PS_SLAB_X, CMD_BOX, -256, C_MIN, C_MAX, -1, C_MAX, C_MIN, 0, CULLED},
        '{PS_SLAB_X, CMD_BOX, -256, 0, 0, 0, 0, 0, 0, SEEN},
        '{PS_SLAB_X, CMD_BOX, 100, 0, 0, -100, 0, 0, 0, CULLED},
        '{PS_SLAB_X, CMD_BOX, 257, 0, 0, 300, 0, 0, 0, CULLED},
        '{PS_SLAB_X, CMD_BOX, 256, C_MAX, C_MIN, 256, C_MIN, C_MAX, 0, SEEN},
        '{PS_SLAB_X, CMD_SPHERE, -256, C_MIN, C_MAX, 0, 0, 0, 256, SEEN},
        '{PS_SLAB_X, CMD_SPHERE, -257, 0, 0, 0, 0, 0, 256, CULLED},
        '{PS_SLAB_X, CMD_SPHERE, 512, 0, 0, C_MIN, C_MIN, C_MIN, 256, SEEN},
        '{PS_SLAB_X, CMD_SPHERE, 513, 0, 0, 0, 0, 0, 256, CULLED},
        '{PS_SLAB_X, CMD_SPHERE, C_MIN, 0, 0, 0, 0, 0, R_MAX, CULLED},
        '{PS_SLAB_X, CMD_SPHERE, 0, 0, 0, C_MAX, C_MAX, C_MAX, 0, SEEN},
        '{PS_EXTREME, CMD_BOX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX, BY_MODEL},
        '{PS_EXTREME, CMD_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, BY_MODEL},
        '{PS_EXTREME, CMD_SPHERE, C_MAX, C_MAX, C_MAX, 0, 0, 0, R_MAX, BY_MODEL},
        '{PS_EXTREME, CMD_SPHERE, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, BY_MODEL},
        '{PS_EXTREME, CMD_BOX, 0, 0, 0, 0, 0, 0, 0, BY_MODEL},
        '{PS_EXTREME, CMD_SPHERE, -1, -1, -1, -1, -1, -1, 1, BY_MODEL}
    };

    frustum_cull_test #(.PLANES(LANES)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .lo_x         (lo_x),
        .lo_y         (lo_y),
        .lo_z         (lo_z),
        .hi_x         (hi_x),
        .hi_y         (hi_y),
        .hi_z         (hi_z),
        .radius       (radius),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .visible      (visible)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic predict_visible(probe_t p);
        plane_t pl;
        longint nx, ny, nz, d, px, py, pz, acc, floor_val;
        logic vis;
        vis = 1'b1;
        floor_val = (p.cmd == CMD_SPHERE) ? -(longint'(p.rad) * 4096) : 64'sd0;
        for (int k = 0; k < LANES && k < NUM_REGS; k++)
        begin
            pl = plane_t'(plane_shadow[k]);
            nx = pl.nx;
            ny = pl.ny;
            nz = pl.nz;
            d = pl.d;
            if (p.cmd == CMD_SPHERE)
            begin
                px = p.lx;
                py = p.ly;
                pz = p.lz;
            end
            else
            begin
                // positive vertex: zero normal counts as non-negative
                px = (nx >= 0) ? p.hx : p.lx;
                py = (ny >= 0) ? p.hy : p.ly;
                pz = (nz >= 0) ? p.hz : p.lz;
            end
            acc = nx * px + ny * py + nz * pz + d * 4096;
            if (acc < floor_val)
                vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [DATA_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        plane_t p;
        p.nx = norm_t'(nx);
        p.ny = norm_t'(ny);
        p.nz = norm_t'(nz);
        p.d = off_t'(d);
        return p;
    endfunction

    function automatic int pick_extreme(int w);
        case ($urandom_range(4))
            0: return -(1 << (w - 1));
            1: return (1 << (w - 1)) - 1;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_plane();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick < 3)
            return {$urandom, $urandom};
        if (pick < 5)
            return '0;
        if (pick < 8)
            return pack_plane(pick_extreme(NORM_W), pick_extreme(NORM_W),
                              pick_extreme(NORM_W), pick_extreme(OFF_W));
        // bounded region around the origin: offset kept non-negative
        return pack_plane($signed($urandom) >>> 18, $signed($urandom) >>> 18,
                          $signed($urandom) >>> 18,
                          int'($urandom_range(2097151) >> $urandom_range(12)));
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(15))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            default: return coord_t'($signed($urandom) >>> $urandom_range(30, 12));
        endcase
    endfunction

    function automatic coord_t grow(coord_t c);
        int h;
        h = int'(c) + int'($urandom >> $urandom_range(31, 12));
        if (h > C_TOP)
            h = C_TOP;
        return coord_t'(h);
    endfunction

    function automatic probe_t rand_probe();
        probe_t p;
        p.setup = PS_EXTREME;
        p.cmd = $urandom_range(1) ? CMD_SPHERE : CMD_BOX;
        p.lx = rand_coord();
        p.ly = rand_coord();
        p.lz = rand_coord();
        if ($urandom_range(4) == 0)
        begin
            // unrelated corners, often inverted
            p.hx = rand_coord();
            p.hy = rand_coord();
            p.hz = rand_coord();
        end
        else
        begin
            p.hx = grow(p.lx);
            p.hy = grow(p.ly);
            p.hz = grow(p.lz);
        end
        case ($urandom_range(9))
            0: p.rad = '0;
            1: p.rad = R_MAX;
            default: p.rad = RAD_W'($urandom >> $urandom_range(31, 13));
        endcase
        p.want = BY_MODEL;
        return p;
    endfunction

    task automatic apb_access(logic wr, int idx, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_W'(idx * 8);
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr && idx < NUM_REGS)
            plane_shadow[idx] = wdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic verify_planes();
        logic [DATA_W-1:0] got;
        for (int k = 0; k < NUM_REGS; k++)
        begin
            apb_access(1'b0, k, '0, got);
            if (got !== plane_shadow[k])
                report_mismatch($sformatf("plane %0d reads %h, expected %h",
                                          k, got, plane_shadow[k]));
        end
    endtask

    // slots past the last register are written too; those writes must not land
    task automatic program_planes(logic [DATA_W-1:0] vals [SLOTS]);
        logic [DATA_W-1:0] unused;
        for (int k = 0; k < SLOTS; k++)
            apb_access(1'b1, k, vals[k], unused);
        verify_planes();
    endtask

    task automatic load_plane_set(plane_set_e ps);
        logic [DATA_W-1:0] vals [SLOTS];
        for (int k = 0; k < SLOTS; k++)
            vals[k] = (k < NUM_REGS) ? '0 : '1;
        case (ps)
            PS_SLAB_X:
            begin
                vals[0] = pack_plane(4096, 0, 0, 0);       // x >= 0
                vals[1] = pack_plane(-4096, 0, 0, 256);    // x <= 1.0
            end
            PS_EXTREME:
            begin
                vals[0] = pack_plane(-8192, 8191, 0, 2097151);
                vals[1] = pack_plane(8191, -8192, -1, -2097152);
                vals[2] = pack_plane(0, 0, 0, 1);
                vals[3] = pack_plane(1, -1, -8192, 0);
                vals[4] = pack_plane(-1, 0, 8191, -1);
                vals[5] = '1;
            end
            default: ;
        endcase
        program_planes(vals);
    endtask

    task automatic send_item(probe_t p, bit gaps_on);
        while (gaps_on && $urandom_range(99) < 35)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        command <= p.cmd;
        lo_x <= p.lx;
        lo_y <= p.ly;
        lo_z <= p.lz;
        hi_x <= p.hx;
        hi_y <= p.hy;
        hi_z <= p.hz;
        radius <= p.rad;
        want_q <= p.want;
        do @(posedge clk); while (item_stall);
    endtask

    // starts on a fresh edge so the last transaction's expectation is already queued
    task automatic wait_drained();
        do @(posedge clk); while (visible_due.size() != 0);
    endtask

    always @(posedge clk)
    begin : watch
        probe_t seen;
        due_t head;
        due_t fresh;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (visible_due.size() == 0)
                    report_mismatch($sformatf("unexpected result, visible=%b", visible));
                else
                begin
                    head = visible_due.pop_front();
                    if (visible !== head.vis)
                        report_mismatch($sformatf("transaction %0d: visible=%b, expected %b",
                                                  head.tag, visible, head.vis));
                end
            end
            if (item_valid && !item_stall)
            begin
                seen.setup = PS_EXTREME;
                seen.cmd = command;
                seen.lx = lo_x;
                seen.ly = lo_y;
                seen.lz = lo_z;
                seen.hx = hi_x;
                seen.hy = hi_y;
                seen.hz = hi_z;
                seen.rad = radius;
                seen.want = want_q;
                fresh.tag = accepted_count;
                fresh.vis = (want_q == BY_MODEL) ? predict_visible(seen) : want_q[0];
                visible_due.push_back(fresh);
                accepted_count++;
            end
        end
    end

    initial
    begin : result_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !steady && ($urandom_range(99) < 35);
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] vals [SLOTS];
        plane_set_e cur;
        int burst_left;
        bit quiet;
        burst_left = 0;
        quiet = 1'b0;
        for (int k = 0; k < NUM_REGS; k++)
            plane_shadow[k] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        verify_planes();

        cur = PS_AFTER_RESET;
        for (int i = 0; i < $size(probes); i++)
        begin
            if (probes[i].setup != cur)
            begin
                item_valid <= 1'b0;
                wait_drained();
                load_plane_set(probes[i].setup);
                cur = probes[i].setup;
            end
            send_item(probes[i], 1'b1);
        end

        for (int ep = 0; ep < EPOCHS; ep++)
        begin
            item_valid <= 1'b0;
            wait_drained();
            for (int k = 0; k < SLOTS; k++)
                vals[k] = rand_plane();
            program_planes(vals);
            for (int n = 0; n < PER_EPOCH; n++)
            begin
                if (ep == 1 && n == 20)
                begin
                    // receiver holds off while we keep the input busy
                    hold_asks <= hold_asks + 1;
                    burst_left = 30;
                end
                if (ep == 2 && n == 60)
                begin
                    item_valid <= 1'b0;
                    wait_drained();
                end
                if (ep == 3 && n == 0)
                begin
                    quiet = 1'b1;
                    steady <= 1'b1;
                end
                if (ep == 3 && n == 100)
                begin
                    quiet = 1'b0;
                    steady <= 1'b0;
                end
                send_item(rand_probe(), !quiet && burst_left == 0);
                if (burst_left > 0)
                    burst_left--;
            end
        end

        item_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (visible_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", visible_due.size()));
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- frustum_cull_test.f -----
+incdir+hw/rtl
hw/rtl/fct_pkg.sv
hw/rtl/fct_cfg.sv
hw/rtl/fct_pipe.sv
hw/rtl/frustum_cull_test.sv
hw/rtl/fct_checker.sv
bench/tb_frustum_cull_test.sv
